/* src/i2cm_pkg.sv */
// ---------------------------------------------------------------------------
// i2cm_pkg
// Shared types and codes for the I2C master bit engine: command codes,
// sequencer states and phases, the queued command record and the pin event
// record.
// ---------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

    // Command codes as they arrive on the op field
    typedef enum logic [2:0] {
        OP_START    = 3'd0,
        OP_STOP     = 3'd1,
        OP_WRITE    = 3'd2,
        OP_READ     = 3'd3,
        OP_SEND_ACK = 3'd4,
        OP_RECV_ACK = 3'd5
    } t_op;

    // Bit sequencer states
    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    // Sequencer phase within one bit slot (or within a short command)
    localparam logic [1:0] PH_STEP0 = 2'd0;
    localparam logic [1:0] PH_STEP1 = 2'd1;
    localparam logic [1:0] PH_STEP2 = 2'd2;
    localparam logic [1:0] PH_STEP3 = 2'd3;
    // Release SDA before the first clock of a receive
    localparam logic [1:0] PH_PRE   = PH_STEP3;

    // Last bit position of a byte, MSB first
    localparam logic [2:0] LAST_BIT = 3'd7;

    // Command queue between the front and the back
    localparam int QDEPTH = 2;
    localparam int QCNT_W = $clog2(QDEPTH + 1);
    localparam int QPTR_W = $clog2(QDEPTH);

    // Reset value of the wait register
    localparam logic [15:0] WAIT_RESET = 16'd720;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
        logic       ack_bit;
        logic [7:0] line_bits;
    } t_cmd;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sample_point;
        logic       hold_after;
        logic [7:0] read_value;
        logic       last_event;
    } t_event;

endpackage

`default_nettype wire

/* src/i2cm_front.sv */
// ---------------------------------------------------------------------------
// i2cm_front
// Accepts commands, drops unknown op codes and holds known commands in a
// short queue until the bit sequencer takes them.
// ---------------------------------------------------------------------------
`default_nettype none

module i2cm_front (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_push,
    output logic                  o_full,
    input  wire  [2:0]            i_op,
    input  wire  [7:0]            i_data_byte,
    input  wire                   i_ack_bit,
    input  wire  [7:0]            i_line_bits,
    output logic                  o_cmd_valid,
    output i2cm_pkg::t_cmd        o_cmd,
    input  wire                   i_cmd_take
);

    i2cm_pkg::t_cmd                  r_q [i2cm_pkg::QDEPTH];
    logic [i2cm_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [i2cm_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [i2cm_pkg::QCNT_W-1:0]     r_count;
    logic [i2cm_pkg::QCNT_W-1:0]     n_count;
    logic                            op_known;
    logic                            enq;
    logic                            deq;
    i2cm_pkg::t_cmd                  cmd_in;

    // Classify the op code: codes beyond receive ack are dropped
    always_comb begin
        case (i_op)
            i2cm_pkg::OP_START,
            i2cm_pkg::OP_STOP,
            i2cm_pkg::OP_WRITE,
            i2cm_pkg::OP_READ,
            i2cm_pkg::OP_SEND_ACK,
            i2cm_pkg::OP_RECV_ACK: op_known = 1'b1;
            default:               op_known = 1'b0;
        endcase
    end

    assign cmd_in.op        = i2cm_pkg::t_op'(i_op);
    assign cmd_in.data_byte = i_data_byte;
    assign cmd_in.ack_bit   = i_ack_bit;
    assign cmd_in.line_bits = i_line_bits;

    assign o_full      = (r_count == i2cm_pkg::QCNT_W'(i2cm_pkg::QDEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    assign enq = i_push && !o_full && op_known;
    assign deq = i_cmd_take && o_cmd_valid;

    // Track occupancy
    always_comb begin
        n_count = r_count;
        if (enq && !deq) begin
            n_count = r_count + 1'b1;
        end else if (deq && !enq) begin
            n_count = r_count - 1'b1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (enq) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (deq) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // Store queued commands
    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

/* src/i2cm_back.sv */
// ---------------------------------------------------------------------------
// i2cm_back
// Bit sequencer: walks one command through its pin events, keeps the SCL
// and SDA drive state and the receive shifter, and holds each event in an
// output register until it is popped.
// ---------------------------------------------------------------------------
`default_nettype none

module i2cm_back (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cmd_valid,
    input  i2cm_pkg::t_cmd        i_cmd,
    output logic                  o_cmd_take,
    output logic                  o_ev_valid,
    output i2cm_pkg::t_event      o_ev,
    input  wire                   i_ev_take
);

    i2cm_pkg::t_seq_state r_state;
    i2cm_pkg::t_seq_state n_state;
    i2cm_pkg::t_cmd      r_cmd;
    logic [1:0]          r_phase;
    logic [1:0]          n_phase;
    logic [2:0]          r_bit;
    logic [2:0]          n_bit;
    logic                r_scl;
    logic                r_sda;
    logic [7:0]          r_rx;
    logic                r_out_valid;
    i2cm_pkg::t_event    r_out;
    i2cm_pkg::t_event    ev;
    logic                shift_in;
    logic                emit;
    logic                is_rx_cmd;

    assign is_rx_cmd = (r_cmd.op == i2cm_pkg::OP_READ) ||
                       (r_cmd.op == i2cm_pkg::OP_RECV_ACK);

    // Build the current pin event and the next position
    always_comb begin
        ev.scl_level    = r_scl;
        ev.sda_level    = r_sda;
        ev.sample_point = 1'b0;
        ev.hold_after   = 1'b0;
        ev.last_event   = 1'b0;
        n_phase         = r_phase + 1'b1;
        n_bit           = r_bit;
        shift_in        = 1'b0;
        case (r_cmd.op)
            i2cm_pkg::OP_START: begin
                case (r_phase)
                    i2cm_pkg::PH_STEP0: ev.sda_level = 1'b1;
                    i2cm_pkg::PH_STEP1: begin
                        ev.scl_level  = 1'b1;
                        ev.hold_after = 1'b1;
                    end
                    i2cm_pkg::PH_STEP2: ev.sda_level = 1'b0;
                    default: begin
                        ev.scl_level  = 1'b0;
                        ev.hold_after = 1'b1;
                        ev.last_event = 1'b1;
                    end
                endcase
            end
            i2cm_pkg::OP_STOP: begin
                case (r_phase)
                    i2cm_pkg::PH_STEP0: ev.sda_level = 1'b0;
                    i2cm_pkg::PH_STEP1: begin
                        ev.scl_level  = 1'b1;
                        ev.hold_after = 1'b1;
                    end
                    default: begin
                        ev.sda_level  = 1'b1;
                        ev.last_event = 1'b1;
                    end
                endcase
            end
            i2cm_pkg::OP_WRITE, i2cm_pkg::OP_SEND_ACK: begin
                case (r_phase)
                    i2cm_pkg::PH_STEP0: begin
                        ev.sda_level = (r_cmd.op == i2cm_pkg::OP_WRITE) ?
                                       r_cmd.data_byte[i2cm_pkg::LAST_BIT - r_bit] :
                                       r_cmd.ack_bit;
                    end
                    i2cm_pkg::PH_STEP1: begin
                        ev.scl_level  = 1'b1;
                        ev.hold_after = 1'b1;
                    end
                    default: begin
                        ev.scl_level  = 1'b0;
                        ev.hold_after = 1'b1;
                        ev.last_event = (r_cmd.op == i2cm_pkg::OP_SEND_ACK) ||
                                        (r_bit == i2cm_pkg::LAST_BIT);
                        n_phase       = i2cm_pkg::PH_STEP0;
                        n_bit         = r_bit + 1'b1;
                    end
                endcase
            end
            i2cm_pkg::OP_READ, i2cm_pkg::OP_RECV_ACK: begin
                case (r_phase)
                    i2cm_pkg::PH_PRE: begin
                        ev.sda_level = 1'b1;
                        n_phase      = i2cm_pkg::PH_STEP0;
                    end
                    i2cm_pkg::PH_STEP0: begin
                        ev.scl_level  = 1'b1;
                        ev.hold_after = 1'b1;
                    end
                    i2cm_pkg::PH_STEP1: begin
                        ev.sample_point = 1'b1;
                        ev.hold_after   = 1'b1;
                        shift_in        = 1'b1;
                    end
                    default: begin
                        ev.scl_level  = 1'b0;
                        ev.hold_after = 1'b1;
                        ev.last_event = (r_cmd.op == i2cm_pkg::OP_RECV_ACK) ||
                                        (r_bit == i2cm_pkg::LAST_BIT);
                        n_phase       = i2cm_pkg::PH_STEP0;
                        n_bit         = r_bit + 1'b1;
                    end
                endcase
            end
            default: ev.last_event = 1'b1;
        endcase
        ev.read_value = (ev.last_event && is_rx_cmd) ? r_rx : 8'd0;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            i2cm_pkg::SEQ_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = i2cm_pkg::SEQ_RUN;
                end
            end
            i2cm_pkg::SEQ_RUN: begin
                if (emit && ev.last_event) begin
                    n_state = i2cm_pkg::SEQ_IDLE;
                end
            end
            default: n_state = i2cm_pkg::SEQ_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_cmd_take = 1'b0;
        emit       = 1'b0;
        case (r_state)
            i2cm_pkg::SEQ_IDLE: o_cmd_take = i_cmd_valid;
            i2cm_pkg::SEQ_RUN:  emit       = !r_out_valid || i_ev_take;
            default: begin
                o_cmd_take = 1'b0;
                emit       = 1'b0;
            end
        endcase
    end

    // Control state: sequencer, line drive, output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= i2cm_pkg::SEQ_IDLE;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_rx        <= 8'd0;
            r_out_valid <= 1'b0;
            r_phase     <= i2cm_pkg::PH_STEP0;
            r_bit       <= '0;
        end else begin
            r_state <= n_state;
            if (o_cmd_take) begin
                r_bit   <= '0;
                r_phase <= ((i_cmd.op == i2cm_pkg::OP_READ) ||
                            (i_cmd.op == i2cm_pkg::OP_RECV_ACK)) ?
                           i2cm_pkg::PH_PRE : i2cm_pkg::PH_STEP0;
                if ((i_cmd.op == i2cm_pkg::OP_READ) ||
                    (i_cmd.op == i2cm_pkg::OP_RECV_ACK)) begin
                    r_rx <= 8'd0;
                end
            end else if (emit) begin
                r_phase <= n_phase;
                r_bit   <= n_bit;
                r_scl   <= ev.scl_level;
                r_sda   <= ev.sda_level;
                if (shift_in) begin
                    r_rx <= {r_rx[6:0], r_cmd.line_bits[i2cm_pkg::LAST_BIT - r_bit]};
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ev_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: hold the command and the pending event
    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd <= i_cmd;
        end
        if (emit) begin
            r_out <= ev;
        end
    end

    assign o_ev_valid = r_out_valid;
    assign o_ev       = r_out;

endmodule

`default_nettype wire

/* src/i2c_master_bit_engine_top.sv */
// ---------------------------------------------------------------------------
// i2c_master_bit_engine_top
// I2C master bit engine: turns start, stop, byte and ack commands into the
// stream of SCL/SDA pin events that carries them out on the bus.
// ---------------------------------------------------------------------------
// On an idle block the first event of a command reaches the outputs once the push
// has been queued, loaded into the sequencer and registered in the output slot.
// Throughput: one event per cycle while pop is held; a command of N events
// (3 to 25) also takes a load step in the sequencer before its first event.
// The two-entry command queue takes new commands while the sequencer runs.
// Reset (synchronous, active low): both lines released, queues empty,
// wait_cycles back to 720.
`default_nettype none

module i2c_master_bit_engine_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // command side
    input  wire         push,
    output logic        full,
    input  wire  [2:0]  i_op,
    input  wire  [7:0]  i_data_byte,
    input  wire         i_ack_bit,
    input  wire  [7:0]  i_line_bits,
    // event side
    output logic        empty,
    input  wire         pop,
    output logic        o_scl_level,
    output logic        o_sda_level,
    output logic        o_sample_point,
    output logic        o_hold_after,
    output logic [7:0]  o_read_value,
    output logic        o_last_event,
    // configuration
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [15:0] i_cfg_wait_cycles
);

    i2cm_pkg::t_cmd    cmd;
    i2cm_pkg::t_event  ev;
    logic              cmd_valid;
    logic              cmd_take;
    logic              ev_valid;
    logic [15:0]       r_wait_cycles;

    // Hold the wait length for the bus timing downstream
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_cycles <= i2cm_pkg::WAIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_wait_cycles <= i_cfg_wait_cycles;
        end
    end

    // Front: accept and classify commands
    i2cm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .i_ack_bit   (i_ack_bit),
        .i_line_bits (i_line_bits),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    // Back: sequence pin events
    i2cm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_ev_valid  (ev_valid),
        .o_ev        (ev),
        .i_ev_take   (pop)
    );

    assign empty          = !ev_valid;
    assign o_scl_level    = ev.scl_level;
    assign o_sda_level    = ev.sda_level;
    assign o_sample_point = ev.sample_point;
    assign o_hold_after   = ev.hold_after;
    assign o_read_value   = ev.read_value;
    assign o_last_event   = ev.last_event;

    // A configuration write lands in the wait register
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> (r_wait_cycles == $past(i_cfg_wait_cycles)))
        else $error("wait register missed a write");

    // A sample keeps SCL high and is followed by a wait
    a_sample_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_sample_point) |-> (o_scl_level && o_hold_after))
        else $error("sample taken with SCL low or without a wait");

    // Every command ends with SCL low or with SDA released (stop)
    a_end_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_last_event) |-> (!o_scl_level || o_sda_level))
        else $error("command ended with bus lines in a bad state");

    // Received data shows only on the last event
    a_read_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_last_event) |-> (o_read_value == 8'd0))
        else $error("read value on an event that is not the last");

endmodule

`default_nettype wire
